### design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types and constants for the decoder, its output queue and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  typedef enum logic [1:0] {
    STATUS_UNIT = 2'd0,
    STATUS_END  = 2'd1,
    STATUS_ERR  = 2'd2
  } status_e;

  // A result group holds one code unit, or two for a surrogate pair.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    status_e     status;
    logic        two;
  } grp_t;

  localparam logic [20:0] MinTwoByte   = 21'h00080;
  localparam logic [20:0] MinThreeByte = 21'h00800;
  localparam logic [20:0] SurrLow      = 21'h0d800;
  localparam logic [20:0] SurrEnd      = 21'h0e000;
  localparam logic [20:0] MinFourByte  = 21'h10000;
  localparam logic [20:0] MaxPlusOne   = 21'h110000;
  localparam logic [5:0]  HighSurrTag  = 6'b110110;
  localparam logic [5:0]  LowSurrTag   = 6'b110111;

endpackage

`default_nettype wire

### design/u8u16_if.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder channel interfaces
// Byte input channel and code unit output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output code_unit, output status, output last, input ready);
  modport sink (input valid, input code_unit, input status, input last, output ready);
endinterface

`default_nettype wire

### design/utf8_to_utf16_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Decodes a NUL-terminated UTF-8 byte stream into UTF-16 code units.
// ----------------------------------------------------------------------------
// Usage: bytes enter on in_i, one item per byte, and code units leave on
// out_o, one item per code unit, with a status and a last flag.
// A clean NUL gives an end marker; a malformed sequence gives one error
// item, after which bytes are dropped up to and including the next NUL,
// unless the malformed byte is itself a NUL. A byte is held in an input
// register, decoded from there and written into a two-entry result queue,
// from which any items it gives are offered. One byte is taken every
// cycle while the result queue is not full; the final byte of a four-byte
// sequence gives two items, which the output sends one after the other.
// Input ready depends only on registered state, never on out_o.ready.
// When the receiver stalls, the queue fills and ready drops; no item is
// lost. Reset clears the sequence state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u8u16_in_if.sink    in_i,
  u8u16_out_if.source out_o
);

  logic            push;
  logic            full;
  u8u16_pkg::grp_t grp;

  u8u16_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.in_byte),
    .full_i     (full),
    .push_o     (push),
    .grp_o      (grp)
  );

  u8u16_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .grp_i       (grp),
    .full_o      (full),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .code_unit_o (out_o.code_unit),
    .status_o    (out_o.status),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

### design/u8u16_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 byte decoder
// Input byte register, sequence state and the per-byte decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output u8u16_pkg::grp_t        grp_o
);

  logic        valid_q, valid_d;
  logic [7:0]  byte_q;
  logic [1:0]  left_q, left_d;
  logic [1:0]  len_q, len_d;
  logic [20:0] part_q, part_d;
  logic        disc_q, disc_d;
  logic        consume;
  logic        has_res;
  logic [20:0] part_new;
  logic [1:0]  left_new;
  logic [20:0] vm;
  logic        bad;

  assign consume    = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign push_o     = consume && has_res;
  assign part_new   = {part_q[14:0], byte_q[5:0]};
  assign left_new   = left_q - 2'd1;
  assign vm         = part_new - u8u16_pkg::MinFourByte;

  always_comb begin
    left_d       = left_q;
    len_d        = len_q;
    part_d       = part_q;
    disc_d       = disc_q;
    has_res      = 1'b0;
    bad          = 1'b0;
    grp_o.unit0  = '0;
    grp_o.unit1  = '0;
    grp_o.status = u8u16_pkg::STATUS_UNIT;
    grp_o.two    = 1'b0;
    if (disc_q) begin
      if (byte_q == 8'h00) begin
        disc_d = 1'b0;
      end
    end else if (left_q == 2'd0) begin
      if (byte_q == 8'h00) begin
        has_res      = 1'b1;
        grp_o.status = u8u16_pkg::STATUS_END;
      end else if (!byte_q[7]) begin
        has_res     = 1'b1;
        grp_o.unit0 = {8'h00, byte_q};
      end else if (byte_q[7:5] == 3'b110) begin
        part_d = {16'h0000, byte_q[4:0]};
        len_d  = 2'd1;
        left_d = 2'd1;
      end else if (byte_q[7:4] == 4'b1110) begin
        part_d = {17'h00000, byte_q[3:0]};
        len_d  = 2'd2;
        left_d = 2'd2;
      end else if (byte_q[7:3] == 5'b11110) begin
        part_d = {18'h00000, byte_q[2:0]};
        len_d  = 2'd3;
        left_d = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else if (byte_q[7:6] != 2'b10) begin
      bad = 1'b1;
    end else if (left_new != 2'd0) begin
      part_d = part_new;
      left_d = left_new;
    end else begin
      part_d = '0;
      len_d  = '0;
      left_d = '0;
      case (len_q)
        2'd1: begin
          if (part_new < u8u16_pkg::MinTwoByte) begin
            bad = 1'b1;
          end else begin
            has_res     = 1'b1;
            grp_o.unit0 = part_new[15:0];
          end
        end
        2'd2: begin
          if (part_new < u8u16_pkg::MinThreeByte ||
              (part_new >= u8u16_pkg::SurrLow && part_new < u8u16_pkg::SurrEnd)) begin
            bad = 1'b1;
          end else begin
            has_res     = 1'b1;
            grp_o.unit0 = part_new[15:0];
          end
        end
        default: begin
          if (part_new < u8u16_pkg::MinFourByte || part_new >= u8u16_pkg::MaxPlusOne) begin
            bad = 1'b1;
          end else begin
            has_res     = 1'b1;
            grp_o.unit0 = {u8u16_pkg::HighSurrTag, vm[19:10]};
            grp_o.unit1 = {u8u16_pkg::LowSurrTag, vm[9:0]};
            grp_o.two   = 1'b1;
          end
        end
      endcase
    end
    if (bad) begin
      left_d       = '0;
      len_d        = '0;
      part_d       = '0;
      disc_d       = (byte_q != 8'h00);
      has_res      = 1'b1;
      grp_o.unit0  = '0;
      grp_o.unit1  = '0;
      grp_o.two    = 1'b0;
      grp_o.status = u8u16_pkg::STATUS_ERR;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (consume) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
      len_q   <= '0;
      part_q  <= '0;
      disc_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (consume) begin
        left_q <= left_d;
        len_q  <= len_d;
        part_q <= part_d;
        disc_q <= disc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

### design/u8u16_outq.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 output queue
// Two-entry queue of result groups, sent one code unit per item.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire u8u16_pkg::grp_t grp_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output logic [15:0]          code_unit_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  u8u16_pkg::grp_t mem_q [2];
  logic            wr_q, rd_q, sub_q;
  logic [1:0]      cnt_q;
  u8u16_pkg::grp_t head;
  logic            pop_unit, pop_grp;

  assign head        = mem_q[rd_q];
  assign full_o      = (cnt_q == 2'd2);
  assign valid_o     = (cnt_q != 2'd0);
  assign code_unit_o = sub_q ? head.unit1 : head.unit0;
  assign status_o    = head.status;
  assign last_o      = !head.two || sub_q;
  assign pop_unit    = valid_o && ready_i;
  assign pop_grp     = pop_unit && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      sub_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_grp) begin
        rd_q  <= !rd_q;
        sub_q <= 1'b0;
      end else if (pop_unit) begin
        sub_q <= 1'b1;
      end
      if (push_i && !pop_grp) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i && pop_grp) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= grp_i;
    end
  end

endmodule

`default_nettype wire

### test/utf8_to_utf16_decoder_top_test.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder testbench
// Sends NUL-terminated byte strings into the decoder, well-formed ones mixed
// with bad lead bytes, broken and overlong sequences, encoded surrogates and
// values beyond the Unicode range. Every code unit coming out is checked
// against a behavioral decoder kept in this module. Both sides idle at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder_top_test;

  typedef struct packed {
    logic       hold;
    logic [7:0] data;
  } stim_t;

  typedef struct packed {
    logic [15:0]         unit;
    u8u16_pkg::status_e  status;
    logic                last;
  } unit_exp_t;

  logic clk;
  logic rst_n;

  u8u16_in_if  in_if ();
  u8u16_out_if out_if ();

  utf8_to_utf16_decoder_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  stim_t     byte_q[$];
  unit_exp_t pending_units[$];
  stim_t     head;
  unit_exp_t want;

  logic [1:0]  cont_left;
  logic [1:0]  seq_len;
  logic [20:0] acc;
  logic        dropping;

  int tx_gap;
  int rx_stall;
  bit tx_calm;
  bit rx_calm;
  int fail_cnt;
  int n_bytes;
  int n_units;
  int n_pairs;
  int n_errs;
  int n_ends;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
  end

  // Behavioral decoder: queues the code units that one byte produces.
  function automatic void add_unit(input logic [15:0] unit, input u8u16_pkg::status_e st,
                                   input logic last);
    unit_exp_t e;
    e.unit = unit;
    e.status = st;
    e.last = last;
    pending_units.push_back(e);
  endfunction

  function automatic void reject(input logic is_nul);
    cont_left = 2'd0;
    seq_len = 2'd0;
    acc = '0;
    dropping = !is_nul;
    add_unit(16'h0000, u8u16_pkg::STATUS_ERR, 1'b1);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [20:0] v;
    logic [20:0] w;
    logic [1:0]  len;
    if (dropping) begin
      if (b == 8'h00) dropping = 1'b0;
    end else if (cont_left == 2'd0) begin
      if (b == 8'h00) begin
        add_unit(16'h0000, u8u16_pkg::STATUS_END, 1'b1);
      end else if (b[7] == 1'b0) begin
        add_unit({8'h00, b}, u8u16_pkg::STATUS_UNIT, 1'b1);
      end else if (b[7:5] == 3'b110) begin
        acc = {16'h0, b[4:0]};
        seq_len = 2'd1;
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc = {17'h0, b[3:0]};
        seq_len = 2'd2;
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc = {18'h0, b[2:0]};
        seq_len = 2'd3;
        cont_left = 2'd3;
      end else begin
        reject(1'b0);
      end
    end else if (b[7:6] != 2'b10) begin
      reject(b == 8'h00);
    end else begin
      acc = {acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        v = acc;
        len = seq_len;
        seq_len = 2'd0;
        acc = '0;
        if (len == 2'd1) begin
          if (v < u8u16_pkg::MinTwoByte) reject(1'b0);
          else add_unit(v[15:0], u8u16_pkg::STATUS_UNIT, 1'b1);
        end else if (len == 2'd2) begin
          if (v < u8u16_pkg::MinThreeByte ||
              (v >= u8u16_pkg::SurrLow && v < u8u16_pkg::SurrEnd)) reject(1'b0);
          else add_unit(v[15:0], u8u16_pkg::STATUS_UNIT, 1'b1);
        end else if (v < u8u16_pkg::MinFourByte || v >= u8u16_pkg::MaxPlusOne) begin
          reject(1'b0);
        end else begin
          w = v - u8u16_pkg::MinFourByte;
          add_unit({u8u16_pkg::HighSurrTag, w[19:10]}, u8u16_pkg::STATUS_UNIT, 1'b0);
          add_unit({u8u16_pkg::LowSurrTag, w[9:0]}, u8u16_pkg::STATUS_UNIT, 1'b1);
        end
      end
    end
  endfunction

  // Stimulus building.
  function automatic void add_byte(input logic [7:0] b);
    byte_q.push_back('{1'b0, b});
  endfunction

  function automatic void add_hold();
    byte_q.push_back('{1'b1, 8'h00});
  endfunction

  function automatic void add_char(input logic [20:0] v, input int len);
    case (len)
      1: add_byte({1'b0, v[6:0]});
      2: begin
        add_byte({3'b110, v[10:6]});
        add_byte({2'b10, v[5:0]});
      end
      3: begin
        add_byte({4'b1110, v[15:12]});
        add_byte({2'b10, v[11:6]});
        add_byte({2'b10, v[5:0]});
      end
      default: begin
        add_byte({5'b11110, v[20:18]});
        add_byte({2'b10, v[17:12]});
        add_byte({2'b10, v[11:6]});
        add_byte({2'b10, v[5:0]});
      end
    endcase
  endfunction

  function automatic void add_broken_char();
    int          len;
    int          kind;
    logic [20:0] v;
    logic [7:0]  r;
    kind = $urandom_range(0, 6);
    len = $urandom_range(2, 4);
    r = 8'($urandom_range(0, 255));
    case (kind)
      0: add_byte($urandom_range(0, 1) ? {2'b10, r[5:0]} : {5'b11111, r[2:0]});
      1: begin
        if (len == 2) v = 21'($urandom_range(0, 'h7f));
        else if (len == 3) v = 21'($urandom_range(0, 'h7ff));
        else v = 21'($urandom_range(0, 'hffff));
        add_char(v, len);
      end
      2: add_char(21'($urandom_range('hd800, 'hdfff)), 3);
      3: add_char(21'($urandom_range('h110000, 'h1fffff)), 4);
      4, 5: begin
        if (len == 2) add_byte({3'b110, r[4:0]});
        else if (len == 3) add_byte({4'b1110, r[3:0]});
        else add_byte({5'b11110, r[2:0]});
        repeat ($urandom_range(0, len - 2)) add_byte({2'b10, 6'($urandom_range(0, 63))});
        r = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) add_byte(8'h00);
        else if (r[7:6] == 2'b10) add_byte({2'b11, r[5:0]});
        else add_byte(r);
      end
      default: add_byte(r);
    endcase
  endfunction

  function automatic void add_random_char();
    int          pick;
    logic [20:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      add_byte(8'($urandom_range(1, 'h7f)));
    end else if (pick < 55) begin
      add_char(21'($urandom_range('h80, 'h7ff)), 2);
    end else if (pick < 70) begin
      v = 21'($urandom_range('h800, 'hffff));
      if (v >= u8u16_pkg::SurrLow && v < u8u16_pkg::SurrEnd) v = v + 21'h800;
      add_char(v, 3);
    end else if (pick < 85) begin
      add_char(21'($urandom_range('h10000, 'h10ffff)), 4);
    end else begin
      add_broken_char();
    end
  endfunction

  // Byte sender.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.in_byte);
        n_bytes++;
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          head = byte_q[0];
          if (head.hold) begin
            in_if.valid <= 1'b0;
            if (pending_units.size() == 0) head = byte_q.pop_front();
          end else begin
            head = byte_q.pop_front();
            in_if.valid <= 1'b1;
            in_if.in_byte <= head.data;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Code unit receiver and checker.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_units.size() == 0) begin
          $display("%0t: unexpected item unit=%h status=%0d last=%b", $time,
                   out_if.code_unit, out_if.status, out_if.last);
          fail_cnt++;
        end else begin
          want = pending_units.pop_front();
          if (out_if.code_unit !== want.unit || out_if.status !== want.status ||
              out_if.last !== want.last) begin
            $display("%0t: expected unit=%h status=%0d last=%b, got unit=%h status=%0d last=%b",
                     $time, want.unit, want.status, want.last,
                     out_if.code_unit, out_if.status, out_if.last);
            fail_cnt++;
          end
        end
        n_units++;
        if (!out_if.last) n_pairs++;
        if (out_if.status == u8u16_pkg::STATUS_ERR) n_errs++;
        if (out_if.status == u8u16_pkg::STATUS_END) n_ends++;
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int n_chars;
    cont_left = 2'd0;
    seq_len = 2'd0;
    acc = '0;
    dropping = 1'b0;

    // Empty string, ASCII top, smallest two-byte and largest scalar value,
    // a bad lead byte with dropping, overlong two-byte, encoded surrogate,
    // NUL inside a sequence, overlong four-byte.
    add_byte(8'h00);
    add_byte(8'h7f);
    add_char(21'h80, 2);
    add_char(21'h10ffff, 4);
    add_byte(8'hff);
    add_byte(8'h00);
    add_char(21'h7f, 2);
    add_byte(8'h00);
    add_char(21'hd800, 3);
    add_byte(8'h00);
    add_byte(8'he1);
    add_byte(8'h00);
    add_char(21'hffff, 4);
    add_byte(8'h00);
    add_hold();

    while (byte_q.size() < 1150) begin
      n_chars = $urandom_range(0, 8);
      repeat (n_chars) add_random_char();
      if ($urandom_range(0, 9) != 0) add_byte(8'h00);
      if ($urandom_range(0, 29) == 0) add_hold();
    end
    add_byte(8'h00);

    do @(negedge clk); while (byte_q.size() != 0 || in_if.valid);
    while (pending_units.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d bytes; checked %0d code unit items, of them %0d surrogate pairs,",
             n_bytes, n_units, n_pairs);
    $display("%0d error reports and %0d end-of-string markers.", n_errs, n_ends);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(8 * 300000);
    $display("Timed out with %0d items still expected.", pending_units.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
